@@ hdl/pmsn_pkg.sv @@
// Shared types and constants for the pixel mean/std normalizer.
package pmsn_pkg;

  localparam int DEF_MAX_PIXELS = 1048576;

  localparam logic [15:0] SCALE_ONE = 16'd4096;
  localparam logic [15:0] SCALE_MAX = 16'hFFFF;

  localparam logic [1:0] MODE_CFG   = 2'd0;
  localparam logic [1:0] MODE_ACCUM = 2'd1;
  localparam logic [1:0] MODE_IMAGE = 2'd2;

  localparam logic [2:0] CFG_FORMAT      = 3'd0;
  localparam logic [2:0] CFG_MEAN_RED    = 3'd1;
  localparam logic [2:0] CFG_MEAN_GREEN  = 3'd2;
  localparam logic [2:0] CFG_MEAN_BLUE   = 3'd3;
  localparam logic [2:0] CFG_SCALE_RED   = 3'd4;
  localparam logic [2:0] CFG_SCALE_GREEN = 3'd5;
  localparam logic [2:0] CFG_SCALE_BLUE  = 3'd6;

  typedef struct packed {
    logic [15:0] mean;
    logic [15:0] scale;
    logic        flat;
  } img_stats_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_QN,
    ST_MUL_SS,
    ST_SQRT,
    ST_DIV_MEAN,
    ST_DIV_SCALE
  } stats_state_t;

endpackage

@@ hdl/pmsn_lane.sv @@
// One channel lane: subtract mean, multiply by scale, round and saturate.
module pmsn_lane (
  input  logic        clk,
  input  logic        load_prod,
  input  logic        load_out,
  input  logic [7:0]  pix_byte,
  input  logic [15:0] mean,
  input  logic [15:0] scale,
  output logic [23:0] result
);
  import pmsn_pkg::*;

  logic signed [16:0] diff;
  logic signed [33:0] prod_next;
  logic signed [33:0] prod;
  logic signed [34:0] rounded;
  logic signed [34:0] quot;
  logic [23:0]        sat_next;

  assign diff      = $signed({1'b0, pix_byte, 8'd0}) - $signed({1'b0, mean});
  assign prod_next = diff * $signed({1'b0, scale});

  always_comb begin
    rounded = $signed({prod[33], prod}) + 35'sd2048;
    quot    = rounded >>> 12;
    if (quot > 35'sd8388607) begin
      sat_next = 24'h7FFFFF;
    end else if (quot < -35'sd8388608) begin
      sat_next = 24'h800000;
    end else begin
      sat_next = quot[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      prod <= prod_next;
    end
    if (load_out) begin
      result <= sat_next;
    end
  end

endmodule

@@ hdl/pmsn_stats.sv @@
// Frame statistics: accumulate sums, then serial multiply, square root and divide.
module pmsn_stats #(
  parameter int MAX_PIXELS = pmsn_pkg::DEF_MAX_PIXELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc_en,
  input  logic                last,
  input  logic [23:0]         pix_bytes,
  output logic                busy,
  output pmsn_pkg::img_stats_t stats
);
  import pmsn_pkg::*;

  localparam int CNT_W    = $clog2(MAX_PIXELS + 1);
  localparam int N_W      = CNT_W + 2;
  localparam int SUM_W    = CNT_W + 10;
  localparam int SQ_W     = CNT_W + 18;
  localparam int D_W      = SQ_W + N_W;
  localparam int R_W      = (D_W + 1) / 2;
  localparam int DIV_W    = SUM_W + 8;
  localparam int SQ_STEPS = (D_W + 1) / 2;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  stats_state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  byte_sum;
  logic [SQ_W-1:0]   square_sum;
  logic [N_W-1:0]    n;
  logic [D_W-1:0]    mul_a, acc, qn;
  logic [SUM_W-1:0]  mul_b;
  logic [D_W-1:0]    sq_x, sq_res, sq_bit;
  logic [R_W-1:0]    root;
  logic [DIV_W-1:0]  num;
  logic [R_W-1:0]    rem, den;
  logic [STEP_W-1:0] step;
  logic              skip_scale;

  logic [9:0]        add_sum;
  logic [17:0]       add_sq;
  logic [N_W-1:0]    n_calc;
  logic [D_W-1:0]    acc_new, d_val, sq_t, sq_x_new, sq_res_new;
  logic              sq_ge, div_ge, last_step;
  logic [R_W:0]      rem_sh;
  logic [R_W-1:0]    rem_new;
  logic [DIV_W-1:0]  num_new;

  always_comb begin
    add_sum = 10'(pix_bytes[7:0]) + 10'(pix_bytes[15:8]) + 10'(pix_bytes[23:16]);
    add_sq  = 18'(pix_bytes[7:0] * pix_bytes[7:0]) + 18'(pix_bytes[15:8] * pix_bytes[15:8])
            + 18'(pix_bytes[23:16] * pix_bytes[23:16]);
    n_calc  = N_W'({count, 1'b0}) + N_W'(count);
    acc_new = acc + (mul_b[0] ? mul_a : '0);
    d_val   = qn - acc_new;
    sq_t    = sq_res + sq_bit;
    sq_ge   = sq_x >= sq_t;
    sq_x_new   = sq_ge ? sq_x - sq_t : sq_x;
    sq_res_new = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
    rem_sh  = {rem, num[DIV_W-1]};
    div_ge  = rem_sh >= {1'b0, den};
    rem_new = div_ge ? R_W'(rem_sh - {1'b0, den}) : rem_sh[R_W-1:0];
    num_new = {num[DIV_W-2:0], div_ge};
    last_step = step == STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (acc_en && last) state_next = ST_LOAD;
      ST_LOAD:      state_next = (count == '0) ? ST_IDLE : ST_MUL_QN;
      ST_MUL_QN:    if (last_step) state_next = ST_MUL_SS;
      ST_MUL_SS:    if (last_step) state_next = ST_SQRT;
      ST_SQRT:      if (last_step) state_next = ST_DIV_MEAN;
      ST_DIV_MEAN:  if (last_step) state_next = skip_scale ? ST_IDLE : ST_DIV_SCALE;
      ST_DIV_SCALE: if (last_step) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      byte_sum   <= '0;
      square_sum <= '0;
      stats      <= '{mean: 16'd0, scale: SCALE_ONE, flat: 1'b0};
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc_en && count < CNT_W'(MAX_PIXELS)) begin
            count      <= count + CNT_W'(1);
            byte_sum   <= byte_sum + SUM_W'(add_sum);
            square_sum <= square_sum + SQ_W'(add_sq);
          end
        end
        ST_LOAD: begin
          if (count == '0) begin
            stats <= '{mean: 16'd0, scale: SCALE_MAX, flat: 1'b1};
          end
          n     <= n_calc;
          mul_a <= D_W'(square_sum);
          mul_b <= SUM_W'(n_calc);
          acc   <= '0;
          step  <= STEP_W'(SUM_W);
        end
        ST_MUL_QN: begin
          acc   <= acc_new;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
          step  <= step - STEP_W'(1);
          if (last_step) begin
            qn    <= acc_new;
            mul_a <= D_W'(byte_sum);
            mul_b <= byte_sum;
            acc   <= '0;
            step  <= STEP_W'(SUM_W);
          end
        end
        ST_MUL_SS: begin
          acc   <= acc_new;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
          step  <= step - STEP_W'(1);
          if (last_step) begin
            sq_x       <= d_val;
            sq_res     <= '0;
            sq_bit     <= D_W'(1) << (2 * (SQ_STEPS - 1));
            skip_scale <= d_val == '0;
            step       <= STEP_W'(SQ_STEPS);
          end
        end
        ST_SQRT: begin
          sq_x   <= sq_x_new;
          sq_res <= sq_res_new;
          sq_bit <= sq_bit >> 2;
          step   <= step - STEP_W'(1);
          if (last_step) begin
            root <= sq_res_new[R_W-1:0];
            num  <= DIV_W'({byte_sum, 8'd0}) + DIV_W'(n >> 1);
            den  <= R_W'(n);
            rem  <= '0;
            step <= STEP_W'(DIV_W);
          end
        end
        ST_DIV_MEAN: begin
          num  <= num_new;
          rem  <= rem_new;
          step <= step - STEP_W'(1);
          if (last_step) begin
            stats.mean <= num_new[15:0];
            num  <= DIV_W'({n, 12'd0}) + DIV_W'(root >> 1);
            den  <= root;
            rem  <= '0;
            step <= STEP_W'(DIV_W);
            if (skip_scale) begin
              stats.scale <= SCALE_MAX;
              stats.flat  <= 1'b1;
            end
          end
        end
        ST_DIV_SCALE: begin
          num  <= num_new;
          rem  <= rem_new;
          step <= step - STEP_W'(1);
          if (last_step) begin
            stats.scale <= (|num_new[DIV_W-1:16]) ? SCALE_MAX : num_new[15:0];
            stats.flat  <= 1'b0;
          end
        end
        default: ;
      endcase
      if (state != ST_IDLE && state_next == ST_IDLE) begin
        count      <= '0;
        byte_sum   <= '0;
        square_sum <= '0;
      end
    end
  end

  assign busy = state != ST_IDLE;

endmodule

@@ hdl/pixel_mean_std_normalizer_top.sv @@
// Top level of the pixel mean/std normalizer: channel lanes, frame statistics, output stage.
//
// Input stream: tdata carries the 32-bit pixel word, tuser the 2-bit mode,
// tlast the last-pixel flag of a statistics pass. Modes 0 and 2 give one
// output transaction each: tdata holds red, green, blue as signed Q16.8
// (24 bits each), tuser the flat-image flag. Mode 1 and mode 3 give none.
// Each pixel is registered in the lane products, then in the output register;
// one pixel per cycle is taken while the three lanes and the output register
// can advance. A pixel with mode 1 and tlast set closes the pass: the
// statistics unit then runs two serial multiplies, a square root and two
// serial divisions, one bit per cycle (no division of the scale when the
// variance is zero), and s_axis_tready stays low meanwhile.
// Reset clears the accumulators and all valid flags and sets the statistics to mean 0, scale one.
// When the receiver stalls, the output and the lane products hold and
// s_axis_tready drops once both stages are full.
module pixel_mean_std_normalizer_top #(
  parameter int MAX_PIXELS = pmsn_pkg::DEF_MAX_PIXELS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_word
  input  logic [1:0]  s_axis_tuser,   // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_red, out_green, out_blue
  output logic [0:0]  m_axis_tuser,   // flat_image
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pmsn_pkg::*;

  logic [1:0]  pixel_format;
  logic [15:0] mean_cfg [3];
  logic [15:0] scale_cfg [3];

  img_stats_t  stats;
  logic        busy;
  logic        accept, advance, p1_en;
  logic        p1_valid, p1_flat, out_flat;
  logic [7:0]  mem_byte [4];
  logic [7:0]  sel_byte [3];
  logic [15:0] sel_mean [3];
  logic [15:0] sel_scale [3];
  logic [23:0] lane_out [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= 2'd0;
      for (int c = 0; c < 3; c++) begin
        mean_cfg[c]  <= 16'd0;
        scale_cfg[c] <= SCALE_ONE;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORMAT:      pixel_format <= cfg_data[1:0];
        CFG_MEAN_RED:    mean_cfg[0]  <= cfg_data;
        CFG_MEAN_GREEN:  mean_cfg[1]  <= cfg_data;
        CFG_MEAN_BLUE:   mean_cfg[2]  <= cfg_data;
        CFG_SCALE_RED:   scale_cfg[0] <= cfg_data;
        CFG_SCALE_GREEN: scale_cfg[1] <= cfg_data;
        CFG_SCALE_BLUE:  scale_cfg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign p1_en         = !p1_valid || advance;
  assign s_axis_tready = p1_en && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mem_byte[k] = s_axis_tdata[8*k +: 8];
    end
    if (s_axis_tuser == MODE_IMAGE) begin
      for (int c = 0; c < 3; c++) begin
        sel_byte[c]  = mem_byte[c];
        sel_mean[c]  = stats.mean;
        sel_scale[c] = stats.scale;
      end
    end else begin
      for (int c = 0; c < 3; c++) begin
        sel_byte[c]  = pixel_format[1] ? mem_byte[c+1] : mem_byte[c];
        sel_mean[c]  = mean_cfg[c];
        sel_scale[c] = scale_cfg[c];
      end
      if (pixel_format[0]) begin
        sel_byte[0] = pixel_format[1] ? mem_byte[3] : mem_byte[2];
        sel_byte[2] = pixel_format[1] ? mem_byte[1] : mem_byte[0];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pmsn_lane u_lane (
      .clk       (clk),
      .load_prod (p1_en),
      .load_out  (advance),
      .pix_byte  (sel_byte[g]),
      .mean      (sel_mean[g]),
      .scale     (sel_scale[g]),
      .result    (lane_out[g])
    );
  end

  pmsn_stats #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_stats (
    .clk       (clk),
    .rst       (rst),
    .acc_en    (accept && s_axis_tuser == MODE_ACCUM),
    .last      (s_axis_tlast),
    .pix_bytes (s_axis_tdata[23:0]),
    .busy      (busy),
    .stats     (stats)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (p1_en) begin
        p1_valid <= accept && (s_axis_tuser == MODE_CFG || s_axis_tuser == MODE_IMAGE);
      end
      if (advance) begin
        m_axis_tvalid <= p1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p1_en) begin
      p1_flat <= (s_axis_tuser == MODE_IMAGE) && stats.flat;
    end
    if (advance) begin
      out_flat <= p1_flat;
    end
  end

  assign m_axis_tdata = {lane_out[2], lane_out[1], lane_out[0]};
  assign m_axis_tuser = out_flat;

endmodule
